// ===== design/ddc_pkg.sv =====
// Shared types, constants and coefficient tables of the downconverter.
`default_nettype none

package ddc_pkg;

    localparam int CORDIC_ITERS = 16;
    localparam int XY_W         = 34;
    localparam int Z_W          = 34;
    localparam int CS_W         = 16;
    localparam int COEF_W       = 16;
    localparam int CTAB_LEN     = 13;
    localparam int IN_W         = 16;
    localparam int OUT_W        = 16;
    localparam int PHASE_W      = 32;
    localparam int RSTEP_W      = 23;
    localparam int PICK_W       = 48;
    localparam int FCNT_W       = 32;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [APB_AW-1:0] REG_LO_PHASE_STEP = 3'd0;
    localparam logic [APB_AW-1:0] REG_RESAMPLE_STEP = 3'd4;

    localparam logic [PHASE_W-1:0] LO_PHASE_STEP_RST = 32'd640115318;
    localparam logic [RSTEP_W-1:0] RESAMPLE_STEP_RST = 23'd439296;
    localparam logic [RSTEP_W-1:0] RESAMPLE_STEP_MIN = 23'd65536;

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

    typedef logic signed [31:0] t_atan;

    localparam t_atan ATAN_TAB [CORDIC_ITERS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
    };

    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef COEF_TAB [CTAB_LEN] = '{
        -16'sd90,  -16'sd167, -16'sd295, -16'sd430, -16'sd443, -16'sd143,
        16'sd645,  16'sd2003, 16'sd3849, 16'sd5925, 16'sd7849, 16'sd9212,
        16'sd9705
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } t_cordic;

    // Coefficient of tap k in a symmetric filter of the given length.
    function automatic t_coef fir_coef(input int k, input int taps);
        int m;
        m = (k < taps - 1 - k) ? k : taps - 1 - k;
        if (m > CTAB_LEN - 1) begin
            m = CTAB_LEN - 1;
        end
        return COEF_TAB[m];
    endfunction

endpackage

`default_nettype wire

// ===== design/ddc_cordic_cell.sv =====
// One rotation step of the CORDIC chain that produces the oscillator cos and sin.
`default_nettype none

module ddc_cordic_cell #(
    parameter int ITER = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire ddc_pkg::t_cordic i_d,
    output logic                  o_valid,
    output ddc_pkg::t_cordic      o_d
);

    logic signed [ddc_pkg::XY_W-1:0] w_x;
    logic signed [ddc_pkg::XY_W-1:0] w_y;
    logic signed [ddc_pkg::Z_W-1:0]  w_z;
    logic signed [ddc_pkg::XY_W-1:0] w_xs;
    logic signed [ddc_pkg::XY_W-1:0] w_ys;
    logic signed [ddc_pkg::Z_W-1:0]  w_at;
    ddc_pkg::t_cordic                n_d;
    logic                            r_valid;
    ddc_pkg::t_cordic                r_d;

    always_comb begin
        w_x  = i_d.x;
        w_y  = i_d.y;
        w_z  = i_d.z;
        w_xs = w_x >>> ITER;
        w_ys = w_y >>> ITER;
        w_at = ddc_pkg::Z_W'(ddc_pkg::ATAN_TAB[ITER]);
        n_d.flip = i_d.flip;
        if (!w_z[ddc_pkg::Z_W-1]) begin
            n_d.x = w_x - w_ys;
            n_d.y = w_y + w_xs;
            n_d.z = w_z - w_at;
        end else begin
            n_d.x = w_x + w_ys;
            n_d.y = w_y - w_xs;
            n_d.z = w_z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

// ===== design/ddc_fir_cell.sv =====
// One cell of the transposed-form FIR chain: a constant tap and a partial sum.
`default_nettype none

module ddc_fir_cell #(
    parameter int K           = 0,
    parameter int TAPS        = 25,
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 36
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic signed [SAMPLE_BITS-1:0] i_x,
    input  wire logic signed [ACC_W-1:0]       i_sum,
    output logic signed [ACC_W-1:0]            o_sum
);

    localparam ddc_pkg::t_coef H = ddc_pkg::fir_coef(K, TAPS);
    localparam int PROD_W = SAMPLE_BITS + ddc_pkg::COEF_W;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  n_sum;
    logic signed [ACC_W-1:0]  r_sum;

    always_comb begin
        w_prod = i_x * H;
        n_sum  = i_sum + ACC_W'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== design/ddc_mix_fir_resample_top.sv =====
// Top level of the downconverter: NCO mixer, FIR cell chain and nearest-sample picker.
//
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in_re, i_in_im
// out       output     o_out_valid / i_out_stall  o_out_re, o_out_im
// config    input      psel, penable, pwrite      paddr, pwdata, prdata
//
// One sample is in work at a time: the CORDIC cell chain computes its oscillator value,
// then it passes the cos/sin, product and mixer registers and moves all FIR cells at once.
// The next transfer can follow in the cycle after the pick for the sample is made, and the
// sample causes zero or one result, written to the result register at that pick.
// A result waiting in the output register stalls the block only when the next
// sample also produces a result. Reset is synchronous and clears all filter state.
`default_nettype none

module ddc_mix_fir_resample_top #(
    parameter int TAPS          = 25,
    parameter int SAMPLE_BITS   = 16,
    parameter int LO_TABLE_BITS = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [ddc_pkg::IN_W-1:0] i_in_re,
    input  wire logic signed [ddc_pkg::IN_W-1:0] i_in_im,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [ddc_pkg::OUT_W-1:0]    o_out_re,
    output logic signed [ddc_pkg::OUT_W-1:0]    o_out_im,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ddc_pkg::APB_AW-1:0]     paddr,
    input  wire logic [ddc_pkg::APB_DW-1:0]     pwdata,
    output logic [ddc_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    localparam int ACC_W  = SAMPLE_BITS + ddc_pkg::COEF_W + $clog2(TAPS);
    localparam int PC_W   = $clog2(TAPS + 1);
    localparam int PROD_W = 2 * ddc_pkg::IN_W;
    localparam int MIX_W  = PROD_W + 2;
    localparam logic [ddc_pkg::PHASE_W-1:0] QMASK =
        ~((ddc_pkg::PHASE_W'(1) << (ddc_pkg::PHASE_W - LO_TABLE_BITS)) - 1'b1);
    localparam logic signed [MIX_W-1:0] SMAX =
        MIX_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [MIX_W-1:0] SMIN = ~SMAX;
    localparam logic signed [ACC_W-1:0] OMAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] OMIN = ~OMAX;
    localparam logic [PC_W-1:0] PRIME_END = PC_W'(TAPS);

    // Configuration registers.
    logic [ddc_pkg::PHASE_W-1:0] r_lo_phase_step;
    logic [ddc_pkg::RSTEP_W-1:0] r_resample_step;
    logic                        w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_phase_step <= ddc_pkg::LO_PHASE_STEP_RST;
            r_resample_step <= ddc_pkg::RESAMPLE_STEP_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == ddc_pkg::REG_RESAMPLE_STEP[2]) begin
                r_resample_step <= pwdata[ddc_pkg::RSTEP_W-1:0];
            end else begin
                r_lo_phase_step <= pwdata;
            end
        end
    end

    always_comb begin
        if (paddr[2] == ddc_pkg::REG_LO_PHASE_STEP[2]) begin
            prdata = r_lo_phase_step;
        end else begin
            prdata = ddc_pkg::APB_DW'(r_resample_step);
        end
    end

    // Input transfer and oscillator phase.
    logic                        r_busy;
    logic                        w_in_fire;
    logic [ddc_pkg::PHASE_W-1:0] r_nco_phase;
    logic signed [ddc_pkg::IN_W-1:0] r_in_re;
    logic signed [ddc_pkg::IN_W-1:0] r_in_im;
    logic [ddc_pkg::PHASE_W-1:0] w_ang;
    logic [ddc_pkg::PHASE_W-1:0] w_ang_q;
    logic [ddc_pkg::PHASE_W-1:0] w_ang_r;
    logic                        w_flip;

    assign o_in_stall = r_busy;
    assign w_in_fire  = i_in_valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nco_phase <= '0;
        end else if (w_in_fire) begin
            r_nco_phase <= r_nco_phase + r_lo_phase_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_re <= i_in_re;
            r_in_im <= i_in_im;
        end
    end

    // The angle is folded into the right half plane before the rotation chain.
    ddc_pkg::t_cordic w_cd [ddc_pkg::CORDIC_ITERS+1];
    logic             w_cv [ddc_pkg::CORDIC_ITERS+1];

    always_comb begin
        w_ang   = '0 - (r_nco_phase & QMASK);
        w_ang_q = w_ang + 32'h4000_0000;
        w_flip  = w_ang_q[ddc_pkg::PHASE_W-1];
        w_ang_r = w_flip ? (w_ang + 32'h8000_0000) : w_ang;
        w_cd[0].x    = ddc_pkg::CORDIC_X0;
        w_cd[0].y    = '0;
        w_cd[0].z    = ddc_pkg::Z_W'(signed'(w_ang_r));
        w_cd[0].flip = w_flip;
        w_cv[0]      = w_in_fire;
    end

    for (genvar i = 0; i < ddc_pkg::CORDIC_ITERS; i++) begin : g_cordic
        ddc_cordic_cell #(
            .ITER(i)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_cv[i]),
            .i_d    (w_cd[i]),
            .o_valid(w_cv[i+1]),
            .o_d    (w_cd[i+1])
        );
    end

    // Oscillator value rounded to Q1.14.
    logic signed [ddc_pkg::XY_W-1:0] w_xf;
    logic signed [ddc_pkg::XY_W-1:0] w_yf;
    logic signed [ddc_pkg::XY_W-1:0] w_xr;
    logic signed [ddc_pkg::XY_W-1:0] w_yr;
    logic signed [ddc_pkg::CS_W-1:0] n_cos;
    logic signed [ddc_pkg::CS_W-1:0] n_sin;
    logic signed [ddc_pkg::CS_W-1:0] r_cos;
    logic signed [ddc_pkg::CS_W-1:0] r_sin;
    logic                            r_cs_valid;

    always_comb begin
        w_xf = w_cd[ddc_pkg::CORDIC_ITERS].x;
        w_yf = w_cd[ddc_pkg::CORDIC_ITERS].y;
        w_xr = (w_xf + ddc_pkg::XY_W'(32768)) >>> 16;
        w_yr = (w_yf + ddc_pkg::XY_W'(32768)) >>> 16;
        if (w_cd[ddc_pkg::CORDIC_ITERS].flip) begin
            n_cos = -ddc_pkg::CS_W'(w_xr);
            n_sin = -ddc_pkg::CS_W'(w_yr);
        end else begin
            n_cos = ddc_pkg::CS_W'(w_xr);
            n_sin = ddc_pkg::CS_W'(w_yr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cv[ddc_pkg::CORDIC_ITERS]) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    // Mixer products, then sums rounded and saturated to the tap width.
    logic signed [PROD_W-1:0] r_p_rc;
    logic signed [PROD_W-1:0] r_p_is;
    logic signed [PROD_W-1:0] r_p_rs;
    logic signed [PROD_W-1:0] r_p_ic;
    logic                     r_p_valid;
    logic signed [MIX_W-1:0]  w_mre;
    logic signed [MIX_W-1:0]  w_mim;
    logic signed [SAMPLE_BITS-1:0] n_mix_re;
    logic signed [SAMPLE_BITS-1:0] n_mix_im;
    logic signed [SAMPLE_BITS-1:0] r_mix_re;
    logic signed [SAMPLE_BITS-1:0] r_mix_im;
    logic                          r_mix_valid;

    always_ff @(posedge i_clk) begin
        if (r_cs_valid) begin
            r_p_rc <= r_in_re * r_cos;
            r_p_is <= r_in_im * r_sin;
            r_p_rs <= r_in_re * r_sin;
            r_p_ic <= r_in_im * r_cos;
        end
    end

    always_comb begin
        w_mre = (MIX_W'(r_p_rc) - MIX_W'(r_p_is) + MIX_W'(8192)) >>> 14;
        w_mim = (MIX_W'(r_p_rs) + MIX_W'(r_p_ic) + MIX_W'(8192)) >>> 14;
        if (w_mre > SMAX) begin
            n_mix_re = SAMPLE_BITS'(SMAX);
        end else if (w_mre < SMIN) begin
            n_mix_re = SAMPLE_BITS'(SMIN);
        end else begin
            n_mix_re = SAMPLE_BITS'(w_mre);
        end
        if (w_mim > SMAX) begin
            n_mix_im = SAMPLE_BITS'(SMAX);
        end else if (w_mim < SMIN) begin
            n_mix_im = SAMPLE_BITS'(SMIN);
        end else begin
            n_mix_im = SAMPLE_BITS'(w_mim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_mix_re <= n_mix_re;
            r_mix_im <= n_mix_im;
        end
    end

    // FIR cell chains, one per component.
    logic signed [ACC_W-1:0] w_sum_re [TAPS+1];
    logic signed [ACC_W-1:0] w_sum_im [TAPS+1];

    assign w_sum_re[TAPS] = '0;
    assign w_sum_im[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_fir
        ddc_fir_cell #(
            .K          (k),
            .TAPS       (TAPS),
            .SAMPLE_BITS(SAMPLE_BITS),
            .ACC_W      (ACC_W)
        ) u_cell_re (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (r_mix_valid),
            .i_x    (r_mix_re),
            .i_sum  (w_sum_re[k+1]),
            .o_sum  (w_sum_re[k])
        );
        ddc_fir_cell #(
            .K          (k),
            .TAPS       (TAPS),
            .SAMPLE_BITS(SAMPLE_BITS),
            .ACC_W      (ACC_W)
        ) u_cell_im (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (r_mix_valid),
            .i_x    (r_mix_im),
            .i_sum  (w_sum_im[k+1]),
            .o_sum  (w_sum_im[k])
        );
    end

    // Priming, nearest-sample pick and output register.
    logic                          r_dec_pend;
    logic [PC_W-1:0]               r_prime_count;
    logic [ddc_pkg::FCNT_W-1:0]    r_filt_count;
    logic [ddc_pkg::PICK_W-1:0]    r_pick_time;
    logic [ddc_pkg::PICK_W-1:0]    w_pick_rnd;
    logic [ddc_pkg::RSTEP_W-1:0]   w_step;
    logic                          w_primed;
    logic                          w_emit;
    logic                          w_dec_fire;
    logic signed [ACC_W-1:0]       w_are;
    logic signed [ACC_W-1:0]       w_aim;
    logic signed [ddc_pkg::OUT_W-1:0] n_out_re;
    logic signed [ddc_pkg::OUT_W-1:0] n_out_im;
    logic                          r_out_valid;
    logic signed [ddc_pkg::OUT_W-1:0] r_out_re;
    logic signed [ddc_pkg::OUT_W-1:0] r_out_im;

    always_comb begin
        w_pick_rnd = r_pick_time + ddc_pkg::PICK_W'(32768);
        w_step     = (r_resample_step < ddc_pkg::RESAMPLE_STEP_MIN) ?
                     ddc_pkg::RESAMPLE_STEP_MIN : r_resample_step;
        w_primed   = (r_prime_count == PRIME_END);
        w_emit     = w_primed && (w_pick_rnd[ddc_pkg::PICK_W-1:16] == r_filt_count);
        w_dec_fire = r_dec_pend && !(w_emit && r_out_valid && i_out_stall);
        w_are = (w_sum_re[0] + ACC_W'(32768)) >>> 16;
        w_aim = (w_sum_im[0] + ACC_W'(32768)) >>> 16;
        if (w_are > OMAX) begin
            n_out_re = ddc_pkg::OUT_W'(OMAX);
        end else if (w_are < OMIN) begin
            n_out_re = ddc_pkg::OUT_W'(OMIN);
        end else begin
            n_out_re = ddc_pkg::OUT_W'(w_are);
        end
        if (w_aim > OMAX) begin
            n_out_im = ddc_pkg::OUT_W'(OMAX);
        end else if (w_aim < OMIN) begin
            n_out_im = ddc_pkg::OUT_W'(OMIN);
        end else begin
            n_out_im = ddc_pkg::OUT_W'(w_aim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_cs_valid    <= 1'b0;
            r_p_valid     <= 1'b0;
            r_mix_valid   <= 1'b0;
            r_dec_pend    <= 1'b0;
            r_prime_count <= '0;
            r_filt_count  <= '0;
            r_pick_time   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cs_valid  <= w_cv[ddc_pkg::CORDIC_ITERS];
            r_p_valid   <= r_cs_valid;
            r_mix_valid <= r_p_valid;
            if (w_in_fire) begin
                r_busy <= 1'b1;
            end else if (w_dec_fire) begin
                r_busy <= 1'b0;
            end
            if (r_mix_valid) begin
                r_dec_pend <= 1'b1;
            end else if (w_dec_fire) begin
                r_dec_pend <= 1'b0;
            end
            if (w_dec_fire) begin
                if (!w_primed) begin
                    r_prime_count <= r_prime_count + 1'b1;
                end else begin
                    r_filt_count <= r_filt_count + 1'b1;
                    if (w_emit) begin
                        r_pick_time <= r_pick_time + ddc_pkg::PICK_W'(w_step);
                    end
                end
            end
            if (w_dec_fire && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dec_fire && w_emit) begin
            r_out_re <= n_out_re;
            r_out_im <= n_out_im;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;

endmodule

`default_nettype wire
